FILE: sv/mfr_pkg.sv
// Shared types and constants for the minmod face reconstruction unit.
package mfr_pkg;

  // Fraction width of the fixed-point samples. It cancels in slope*hl/h, so the
  // datapath does not depend on it.
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 2;

  // Work item passed from the slope front end to the divide back end.
  typedef struct packed {
    logic signed [63:0] prod;
    logic signed [31:0] depth;
    logic signed [31:0] velocity;
  } work_t;

endpackage

FILE: sv/mfr_front.sv
// Front end: holds the cell window, forms the minmod slopes and the product.
module mfr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  depth_sample,
  input  logic signed [31:0]  velocity_sample,
  input  logic                row_begin,
  output logic                work_valid,
  input  logic                work_ready,
  output mfr_pkg::work_t      work
);

  logic signed [31:0] held_depth, held_velocity;
  logic signed [32:0] left_depth_step, left_velocity_step;
  logic [1:0]         cells_seen;
  // Stage between slope logic and the multiplier.
  logic               mul_valid;
  logic signed [32:0] mul_hs, mul_hl;
  logic signed [31:0] mul_depth, mul_velocity;
  logic               out_valid;
  mfr_pkg::work_t     out_work;

  logic signed [32:0] rd, rv, mmd, mmv, hl_wide;
  logic signed [31:0] hl;
  logic               emit, take;

  function automatic logic signed [32:0] minmod(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
    logic signed [32:0] r;
    r = '0;
    if (!a[32] && !b[32]) r = (a <= b) ? a : b;
    else if ((a[32] || a == 0) && (b[32] || b == 0)) r = (a >= b) ? a : b;
    return r;
  endfunction

  assign rd = 33'(depth_sample) - 33'(held_depth);
  assign rv = 33'(velocity_sample) - 33'(held_velocity);
  assign mmd = minmod(left_depth_step, rd);
  assign mmv = minmod(left_velocity_step, rv);
  assign hl_wide = 33'(held_depth) - (mmd >>> 1);
  always_comb begin
    if (hl_wide > 33'sd2147483647) hl = 32'sh7fffffff;
    else if (hl_wide < -33'sd2147483648) hl = 32'sh80000000;
    else hl = hl_wide[31:0];
  end

  assign in_ready = !mul_valid || !out_valid || work_ready;
  assign take = in_valid && in_ready;
  assign emit = !row_begin && (cells_seen == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_depth <= '0;
      held_velocity <= '0;
      left_depth_step <= '0;
      left_velocity_step <= '0;
      cells_seen <= '0;
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || work_ready) begin
        out_valid <= mul_valid;
        out_work.prod <= 64'(mul_hs) * 64'(mul_hl);
        out_work.depth <= mul_depth;
        out_work.velocity <= mul_velocity;
      end
      if (in_ready) mul_valid <= take && emit;
      if (take) begin
        if (row_begin || cells_seen == 2'd0) begin
          cells_seen <= 2'd1;
        end else if (cells_seen == 2'd1) begin
          left_depth_step <= rd;
          left_velocity_step <= rv;
          cells_seen <= 2'd2;
        end else begin
          left_depth_step <= rd;
          left_velocity_step <= rv;
          mul_hs <= mmv >>> 1;
          mul_hl <= 33'(hl);
          mul_depth <= held_depth;
          mul_velocity <= held_velocity;
        end
        held_depth <= depth_sample;
        held_velocity <= velocity_sample;
      end
    end
  end

  assign work_valid = out_valid;
  assign work = out_work;

endmodule

FILE: sv/mfr_queue.sv
// Small FIFO between the front end and the divide back end.
module mfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mfr_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mfr_pkg::work_t pop_data
);

  localparam int AW = $clog2(mfr_pkg::QUEUE_DEPTH);
  mfr_pkg::work_t mem [mfr_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          push, pop;

  assign push_ready = count != (AW+1)'(mfr_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

FILE: sv/mfr_back.sv
// Back end: restoring divide of the product by the depth, then saturating add.
module mfr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           work_valid,
  output logic           work_ready,
  input  mfr_pkg::work_t work,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [31:0]    res_face,
  output logic           res_zero
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state;
  logic [63:0]        quot, rem;
  logic [31:0]        divisor;
  logic               q_neg;
  logic [5:0]         step;
  logic signed [31:0] velocity;
  logic [64:0]        trial;
  logic [63:0]        rem_sh;
  logic signed [65:0] sum;
  logic signed [63:0] qs;

  assign work_ready = state == ST_IDLE;
  assign res_valid = state == ST_OUT;
  assign rem_sh = {rem[62:0], quot[63]};
  assign trial = {1'b0, rem_sh} - {33'd0, divisor};
  assign qs = q_neg ? -$signed(quot) : $signed(quot);
  assign sum = 66'(velocity) + 66'(qs);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (work_valid) begin
            velocity <= work.velocity;
            if (work.depth == '0) begin
              res_zero <= 1'b1;
              if (work.prod > 0) res_face <= 32'h7fffffff;
              else if (work.prod < 0) res_face <= 32'h80000000;
              else res_face <= work.velocity;
              state <= ST_OUT;
            end else begin
              res_zero <= 1'b0;
              quot <= work.prod[63] ? -work.prod : work.prod;
              divisor <= work.depth[31] ? -work.depth : work.depth;
              q_neg <= work.prod[63] ^ work.depth[31];
              rem <= '0;
              step <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (!trial[64]) begin
            rem <= trial[63:0];
            quot <= {quot[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quot <= {quot[62:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          if (sum > 66'sd2147483647) res_face <= 32'h7fffffff;
          else if (sum < -66'sd2147483648) res_face <= 32'h80000000;
          else res_face <= sum[31:0];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (res_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/minmod_face_reconstruction_unit.sv
// Top level of the minmod face reconstruction unit.
// An input transfer passes the front end's multiplier stage and output register,
// the queue and the back end's divide, add and output states (a zero-depth cell
// skips both); the bit-serial 64-bit divider takes no work till its result is taken.
// Cells that give no result pass the front end at one per cycle unless it is stalled.
// Reset (rst, synchronous, active high) clears the cell window and all valids.
module minmod_face_reconstruction_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // depth_sample[31:0], velocity_sample[63:32]
  input  logic        s_axis_tuser,  // row_begin
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // velocity_face[31:0]
  output logic        m_axis_tuser   // zero_depth
);

  logic           f_valid, f_ready, b_valid, b_ready;
  mfr_pkg::work_t f_work, b_work;

  mfr_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .depth_sample(s_axis_tdata[31:0]), .velocity_sample(s_axis_tdata[63:32]),
    .row_begin(s_axis_tuser),
    .work_valid(f_valid), .work_ready(f_ready), .work(f_work)
  );

  mfr_queue u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_work),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_work)
  );

  mfr_back u_back (
    .clk, .rst,
    .work_valid(b_valid), .work_ready(b_ready), .work(b_work),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_face(m_axis_tdata), .res_zero(m_axis_tuser)
  );

  // A result stays offered until its transfer completes.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn before its transfer");

  // The back end never takes new work while a result is pending.
  a_back_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !b_ready)
    else $error("back end accepted work with a result pending");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

FILE: verif/minmod_face_reconstruction_unit_tb.sv
// Self-checking testbench for the minmod face reconstruction unit.
module minmod_face_reconstruction_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_CELLS = 1900;

  // Idle modes for the sender and the receiver.
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [31:0] face;
    logic               zero_flag;
  } face_result_t;

  // One directed row of stimulus. When has_expect is set, the row's result is typed in.
  typedef struct {
    logic signed [31:0] depth;
    logic signed [31:0] velocity;
    logic               row_begin;
    logic               has_expect;
    logic signed [31:0] exp_face;
    logic               exp_zero;
  } cell_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // depth_sample[31:0], velocity_sample[63:32]
  logic        s_axis_tuser;   // row_begin
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // velocity_face[31:0]
  logic        m_axis_tuser;   // zero_depth

  minmod_face_reconstruction_unit dut (.*);

  // Window state of the predictor.
  longint     win_depth, win_velocity, win_dh, win_du;
  int         win_count;
  face_result_t pending_faces[$];
  int         error_count;
  int         idle_cycles;
  idle_mode_t idle_mode;
  logic       typed_valid;
  face_result_t typed_face;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_half(longint x);
    return x >>> 1;
  endfunction

  function automatic longint minmod(longint a, longint b);
    if (a >= 0 && b >= 0) return (a <= b) ? a : b;
    if (a <= 0 && b <= 0) return (a >= b) ? a : b;
    return 0;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Advances the cell window by one transfer and queues the face value it yields.
  task automatic predict_face(logic signed [31:0] depth, logic signed [31:0] velocity,
                              logic row_begin);
    longint h, u, rd, rv, hl, hs, prod, face;
    face_result_t r;
    h = depth;
    u = velocity;
    if (row_begin) win_count = 0;
    if (win_count == 0) begin
      win_count = 1;
    end else if (win_count == 1) begin
      win_dh = h - win_depth;
      win_du = u - win_velocity;
      win_count = 2;
    end else begin
      rd = h - win_depth;
      rv = u - win_velocity;
      hl = clamp32(win_depth - floor_half(minmod(win_dh, rd)));
      hs = floor_half(minmod(win_du, rv));
      prod = hs * hl;
      r.zero_flag = (win_depth == 0);
      if (win_depth == 0) begin
        if (prod > 0) face = S32_MAX;
        else if (prod < 0) face = S32_MIN;
        else face = win_velocity;
      end else begin
        // SystemVerilog division truncates toward zero.
        face = clamp32(win_velocity + prod / win_depth);
      end
      r.face = face[31:0];
      // A typed-in expectation must agree with the predictor as well.
      if (typed_valid && r !== typed_face)
        report_mismatch("typed", typed_face.face, r.face);
      pending_faces.push_back(r);
      win_dh = rd;
      win_du = rv;
    end
    win_depth = h;
    win_velocity = u;
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  function automatic bit idle_roll(bit sender);
    case (idle_mode)
      IDLE_SEND: return sender && $urandom_range(99) < 66;
      IDLE_RECV: return !sender && $urandom_range(99) < 66;
      IDLE_BOTH: return $urandom_range(99) < 30;
      default:   return 1'b0;
    endcase
  endfunction

  // Sends one cell and waits until its transfer completes.
  task automatic send_cell(logic signed [31:0] depth, logic signed [31:0] velocity,
                           logic row_begin);
    while (idle_roll(1'b1)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {velocity, depth};
    s_axis_tuser  <= row_begin;
    do @(posedge clk); while (!s_axis_tready);
    predict_face(depth, velocity, row_begin);
  endtask

  // Receiver: random stalls, checks each transfer against the oldest face value.
  always @(posedge clk) begin
    face_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_faces.size() == 0) begin
          report_mismatch("unexpected", 32'h0, m_axis_tdata);
        end else begin
          want = pending_faces.pop_front();
          if (m_axis_tdata !== want.face) report_mismatch("face", want.face, m_axis_tdata);
          if (m_axis_tuser !== want.zero_flag)
            report_mismatch("zero_depth", want.zero_flag, m_axis_tuser);
        end
      end
      m_axis_tready <= !idle_roll(1'b0);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Directed rows: extremes, sign mismatch, zero depth, saturation, row restarts.
  cell_row_t directed [24] = '{
    '{32'sd100, 32'sd0, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd200, 32'sd10, 1'b0, 1'b0, 32'sd0, 1'b0},
    // Equal slopes: hl=200-50=150, hs=5, face=10+750/200=13.
    '{32'sd300, 32'sd20, 1'b0, 1'b1, 32'sd13, 1'b0},
    // Velocity slopes change sign: minmod gives zero, face equals u.
    '{32'sd400, 32'sd0, 1'b0, 1'b1, 32'sd20, 1'b0},
    // A row restart drops the held cell.
    '{32'sd0, 32'sd5, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd0, 32'sd5, 1'b0, 1'b0, 32'sd0, 1'b0},
    // Zero depth with zero slope: face is u, flag set.
    '{32'sd0, 32'sd5, 1'b0, 1'b1, 32'sd5, 1'b1},
    '{32'sd10, 32'sd100, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd0, 32'sd200, 1'b0, 1'b0, 32'sd0, 1'b0},
    // Zero depth, depth slopes differ in sign so hl=0: face is u.
    '{32'sd10, 32'sd300, 1'b0, 1'b1, 32'sd200, 1'b1},
    '{-32'sd10, -32'sd100, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    // Zero depth, hl=-5, slope positive: smallest value.
    '{32'sd10, 32'sd100, 1'b0, 1'b1, 32'h80000000, 1'b1},
    '{32'sh80000000, 32'sh80000000, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sh80000000, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd1, 32'sh80000000, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd1, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd1, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd1, -32'sd7, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd3, -32'sd9, 1'b0, 1'b0, 32'sd0, 1'b0}
  };

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] h, u;
    int run_left;
    error_count = 0;
    idle_mode = IDLE_NONE;
    typed_valid = 1'b0;
    win_depth = 0; win_velocity = 0; win_dh = 0; win_du = 0; win_count = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      typed_valid = directed[i].has_expect;
      typed_face.face = directed[i].exp_face;
      typed_face.zero_flag = directed[i].exp_zero;
      send_cell(directed[i].depth, directed[i].velocity, directed[i].row_begin);
    end
    typed_valid = 1'b0;
    // Hold the sender back until every face value is out.
    wait_drained();

    // Random rows: mostly smooth profiles, some wild values, zero depths and negative depths.
    run_left = 0;
    for (int n = 0; n < RANDOM_CELLS; n++) begin
      if (n % 475 == 0) idle_mode = idle_mode_t'((n / 475) % 4);
      if (run_left == 0) begin
        run_left = $urandom_range(12, 2);
        h = $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22);
        u = $urandom;
        send_cell(h, u, 1'b1);
      end else begin
        case ($urandom_range(9))
          0: begin h = $urandom; u = $urandom; end
          1: begin h = 0; u = u + $signed($urandom_range(2000)) - 1000; end
          2: begin h = -$signed($urandom_range(5000)); u = $urandom; end
          default: begin
            h = h + $signed($urandom_range(1 << 16)) - (1 << 15);
            u = u + $signed($urandom_range(1 << 20)) - (1 << 19);
          end
        endcase
        send_cell(h, u, $urandom_range(30) == 0);
        run_left--;
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
